### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the chunked body decoder.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/hcbd_pkg.sv
// Types, constants and helpers for the chunked body decoder.
// No dependencies; used by every module in rtl/core.
package hcbd_pkg;

  localparam int SIZE_LINE_MAX = 63;
  localparam int SLC_W = $clog2(SIZE_LINE_MAX + 1);

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PLAIN   = 4'd1,
    PH_SIZE    = 4'd2,
    PH_EXT     = 4'd3,
    PH_DATA    = 4'd4,
    PH_END_CR  = 4'd5,
    PH_END_LF  = 4'd6,
    PH_TRAILER = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IGN  = 2'd3
  } status_t;

  // trailer line content so far
  typedef enum logic [1:0] {
    TL_EMPTY   = 2'd0,
    TL_CR_ONLY = 2'd1,
    TL_TEXT    = 2'd2
  } trailer_t;

  typedef struct packed {
    phase_t           phase;
    logic [31:0]      bytes_left;
    logic [SLC_W-1:0] size_line_count;
    logic             pending_cr;
    trailer_t         trailer_line;
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        is_chunked;
    logic [31:0] plain_length;
  } item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    status_t    status;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/hcbd_step.sv
// Next-state and result logic for one item of the chunked body decoder.
// Purely combinational; depends on hcbd_pkg.
module hcbd_step (
  input  hcbd_pkg::state_t  cur,
  input  hcbd_pkg::item_t   item,
  output hcbd_pkg::state_t  nxt,
  output hcbd_pkg::result_t res
);
  import hcbd_pkg::*;

  logic [31:0] dec;
  logic [4:0]  hex;
  logic [7:0]  c;

  assign dec = cur.bytes_left - 32'd1;
  assign c   = item.data_byte;
  assign hex = hex_value(c);

  always_comb begin
    nxt = cur;
    res = '{body_byte: 8'd0, body_valid: 1'b0, status: ST_BUSY};

    if (item.kind == KIND_START) begin
      nxt.size_line_count = '0;
      nxt.pending_cr      = 1'b0;
      nxt.trailer_line    = TL_EMPTY;
      if (item.is_chunked) begin
        nxt.bytes_left = '0;
        nxt.phase      = PH_SIZE;
      end else if (item.plain_length == 32'd0) begin
        nxt.bytes_left = '0;
        nxt.phase      = PH_DONE;
        res.status     = ST_DONE;
      end else begin
        nxt.bytes_left = item.plain_length;
        nxt.phase      = PH_PLAIN;
      end
    end else begin
      case (cur.phase)
        PH_PLAIN, PH_DATA: begin
          res.body_byte  = c;
          res.body_valid = 1'b1;
          nxt.bytes_left = dec;
          if (dec == 32'd0) begin
            if (cur.phase == PH_PLAIN) begin
              nxt.phase  = PH_DONE;
              res.status = ST_DONE;
            end else begin
              nxt.phase = PH_END_CR;
            end
          end
        end
        PH_SIZE, PH_EXT: begin
          if (c == CH_LF) begin
            // end of size line
            nxt.size_line_count = '0;
            nxt.pending_cr      = 1'b0;
            if (cur.bytes_left == 32'd0) begin
              nxt.phase        = PH_TRAILER;
              nxt.trailer_line = TL_EMPTY;
            end else begin
              nxt.phase = PH_DATA;
            end
          end else if (cur.pending_cr) begin
            nxt.phase  = PH_ERROR;
            res.status = ST_ERR;
          end else if (cur.size_line_count >= SLC_W'(SIZE_LINE_MAX)) begin
            nxt.phase  = PH_ERROR;
            res.status = ST_ERR;
          end else begin
            nxt.size_line_count = cur.size_line_count + SLC_W'(1);
            if (cur.phase == PH_EXT) begin
              nxt.phase = PH_EXT;
            end else if (c == CH_SEMI) begin
              nxt.phase = PH_EXT;
            end else if (c == CH_CR) begin
              nxt.pending_cr = 1'b1;
            end else if (hex[4]) begin
              nxt.bytes_left = {cur.bytes_left[27:0], hex[3:0]};
            end else begin
              nxt.phase  = PH_ERROR;
              res.status = ST_ERR;
            end
          end
        end
        PH_END_CR: begin
          if (c == CH_CR) begin
            nxt.phase = PH_END_LF;
          end else begin
            nxt.phase  = PH_ERROR;
            res.status = ST_ERR;
          end
        end
        PH_END_LF: begin
          if (c == CH_LF) begin
            nxt.phase           = PH_SIZE;
            nxt.bytes_left      = '0;
            nxt.size_line_count = '0;
            nxt.pending_cr      = 1'b0;
          end else begin
            nxt.phase  = PH_ERROR;
            res.status = ST_ERR;
          end
        end
        PH_TRAILER: begin
          if (c == CH_LF) begin
            if (cur.trailer_line != TL_TEXT) begin
              nxt.phase  = PH_DONE;
              res.status = ST_DONE;
            end
            nxt.trailer_line = TL_EMPTY;
          end else if (c == CH_CR && cur.trailer_line == TL_EMPTY) begin
            nxt.trailer_line = TL_CR_ONLY;
          end else begin
            nxt.trailer_line = TL_TEXT;
          end
        end
        default: begin
          res.status = ST_IGN;
        end
      endcase
    end
  end

endmodule

### rtl/core/hcbd_out_buf.sv
// Two-entry result queue that decouples the decoder from output stall.
// Depends on hcbd_pkg.
module hcbd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hcbd_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output hcbd_pkg::result_t out_data
);
  import hcbd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign space     = (count != 2'd2);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/http_chunked_body_decoder.sv
// HTTP body decoder (plain length or chunked coding), one result per item.
// The input register and the result queue lie between input transfer and result
// transfer; the result shows on the output once the step result enters the queue.
// Throughput: 1 item per cycle; the input register feeds combinational step
// logic into a 2-entry result queue, so input stalls only when both are full.
// Reset (rst, sync, active high): phase idle, counters clear, queue empty.
module http_chunked_body_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        is_chunked,
  input  logic [31:0] plain_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  body_byte,
  output logic        body_valid,
  output logic [1:0]  status
);
  import hcbd_pkg::*;
  `include "assert_macros.svh"

  // Input register: one item waiting for the step logic.
  logic    item_valid;
  item_t   item;

  // Decoder state, updated once per item that advances.
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t out_res;

  logic    space;
  logic    advance;
  logic    in_take;

  // An item advances whenever the result queue has a free slot.
  assign advance  = item_valid && space;
  assign in_stall = item_valid && !space;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{kind: kind, data_byte: data_byte, is_chunked: is_chunked,
                plain_length: plain_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  hcbd_step u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, bytes_left: '0, size_line_count: '0,
                 pending_cr: 1'b0, trailer_line: TL_EMPTY};
    end else if (advance) begin
      state <= state_next;
    end
  end

  hcbd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign body_byte  = out_res.body_byte;
  assign body_valid = out_res.body_valid;
  assign status     = out_res.status;

  // A payload byte is only ever handed on with busy or done status.
  `ASSERT_IMPL(a_valid_status, out_valid && body_valid, status == ST_BUSY || status == ST_DONE, "payload byte with error or ignored status")
  // Error is sticky until a start transfer reaches the step logic.
  `ASSERT_NEXT(a_err_sticky, state.phase == PH_ERROR && !(advance && item.kind == KIND_START), state.phase == PH_ERROR, "left error phase without a start")
  // Size line counter never passes its limit.
  `ASSERT_CLK(a_line_cnt, state.size_line_count <= SLC_W'(SIZE_LINE_MAX), "size line counter overrun")
  // Data phase always has bytes outstanding.
  `ASSERT_IMPL(a_data_left, state.phase == PH_DATA || state.phase == PH_PLAIN, state.bytes_left != 32'd0, "data phase with zero bytes left")

endmodule
